>>> rtl/core/ps2hlc_pkg.sv
package ps2hlc_pkg;

    localparam int RX_FRAME_BITS = 11;
    localparam int TX_FRAME_BITS = 12;
    localparam int FRAME_BITS = 11;
    localparam int BYTE_BITS = 8;
    localparam int COUNT_BITS = 4;
    localparam int HOLD_BITS = 16;
    localparam logic [HOLD_BITS-1:0] INHIBIT_RESET = 16'd50000;
    localparam int FRAME_COPY_BITS = (RX_FRAME_BITS < FRAME_BITS) ? RX_FRAME_BITS : FRAME_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LINE       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_TICK       = 2'd2,
        OP_FORCE_IDLE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_REJECTED = 2'd2,
        STATUS_FINISHED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_WAIT_IDLE,
        MODE_IDLE,
        MODE_HOLD_CLK,
        MODE_HOLD_DATA,
        MODE_WRITE
    } mode_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic                 clk_level;
        logic                 data_level;
        logic [BYTE_BITS-1:0] write_byte;
    } req_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  frame_valid;
        logic                  clk_drive_low;
        logic                  data_drive_low;
        status_t               status;
    } rsp_t;

    typedef struct packed {
        opcode_t                  op;
        logic                     clk_level;
        logic                     data_level;
        logic [TX_FRAME_BITS-1:0] tx_frame;
    } cmd_t;

    // Byte first, then odd parity and the stop bit, the rest filled with ones.
    function automatic logic [TX_FRAME_BITS-1:0] tx_frame_of(input logic [BYTE_BITS-1:0] b);
        logic [TX_FRAME_BITS-1:0] t;
        t = '1;
        t[BYTE_BITS-1:0] = b;
        t[BYTE_BITS] = ~^b;
        return t;
    endfunction

    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [RX_FRAME_BITS-1:0] rx);
        logic [FRAME_BITS-1:0] f;
        f = '0;
        for (int i = 0; i < FRAME_COPY_BITS; i++)
        begin
            f[i] = rx[i];
        end
        return f;
    endfunction

endpackage

>>> rtl/core/ps2hlc_front.sv
module ps2hlc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ps2hlc_pkg::req_t  req,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output ps2hlc_pkg::cmd_t  cmd
);

    ps2hlc_pkg::cmd_t                         queue_mem [ps2hlc_pkg::QUEUE_DEPTH];
    logic [ps2hlc_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg;
    logic [ps2hlc_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_next;
    logic [ps2hlc_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg;
    logic [ps2hlc_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_next;
    logic [ps2hlc_pkg::QUEUE_CNT_BITS-1:0]    count_reg;
    logic [ps2hlc_pkg::QUEUE_CNT_BITS-1:0]    count_next;
    ps2hlc_pkg::cmd_t                         classified;
    logic                                     push;
    logic                                     pop;

    always_comb
    begin
        classified.clk_level = req.clk_level;
        classified.data_level = req.data_level;
        classified.tx_frame = ps2hlc_pkg::tx_frame_of(req.write_byte);
        unique case (req.opcode)
            ps2hlc_pkg::OP_LINE:  classified.op = ps2hlc_pkg::OP_LINE;
            ps2hlc_pkg::OP_WRITE: classified.op = ps2hlc_pkg::OP_WRITE;
            ps2hlc_pkg::OP_TICK:  classified.op = ps2hlc_pkg::OP_TICK;
            default:              classified.op = ps2hlc_pkg::OP_FORCE_IDLE;
        endcase
    end

    assign req_stall = (count_reg == ps2hlc_pkg::QUEUE_CNT_BITS'(ps2hlc_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push = req_valid && !req_stall;
    assign pop = cmd_pop && cmd_valid;
    assign cmd = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ps2hlc_pkg::QUEUE_PTR_BITS'(ps2hlc_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ps2hlc_pkg::QUEUE_PTR_BITS'(ps2hlc_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/ps2hlc_back.sv
module ps2hlc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [ps2hlc_pkg::HOLD_BITS-1:0]    cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_pop,
    input  ps2hlc_pkg::cmd_t                    cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ps2hlc_pkg::rsp_t                    rsp
);

    logic [ps2hlc_pkg::HOLD_BITS-1:0]      inhibit_ticks_reg;
    ps2hlc_pkg::mode_t                     mode_reg;
    ps2hlc_pkg::mode_t                     mode_next;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]     bits_left_reg;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]     bits_left_next;
    logic [ps2hlc_pkg::RX_FRAME_BITS-1:0]  receive_shift_reg;
    logic [ps2hlc_pkg::RX_FRAME_BITS-1:0]  receive_shift_next;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]     receive_position_reg;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]     receive_position_next;
    logic [ps2hlc_pkg::TX_FRAME_BITS-1:0]  transmit_shift_reg;
    logic [ps2hlc_pkg::TX_FRAME_BITS-1:0]  transmit_shift_next;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]      hold_count_reg;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]      hold_count_next;
    logic                                  clk_held_reg;
    logic                                  clk_held_next;
    logic                                  data_held_reg;
    logic                                  data_held_next;
    logic                                  rsp_valid_reg;
    ps2hlc_pkg::rsp_t                      rsp_reg;
    ps2hlc_pkg::rsp_t                      result;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]      hold_limit;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]      hold_inc;
    logic                                  hold_done;
    logic                                  take;

    assign take = cmd_valid && (!rsp_valid_reg || !rsp_stall);
    assign cmd_pop = take;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    assign hold_limit = (inhibit_ticks_reg == '0) ? ps2hlc_pkg::HOLD_BITS'(1) : inhibit_ticks_reg;
    assign hold_inc = hold_count_reg + 1'b1;
    assign hold_done = (hold_inc >= hold_limit);

    always_comb
    begin
        mode_next = mode_reg;
        bits_left_next = bits_left_reg;
        receive_shift_next = receive_shift_reg;
        receive_position_next = receive_position_reg;
        transmit_shift_next = transmit_shift_reg;
        hold_count_next = hold_count_reg;
        clk_held_next = clk_held_reg;
        data_held_next = data_held_reg;
        result.frame = '0;
        result.frame_valid = 1'b0;
        result.status = ps2hlc_pkg::STATUS_NONE;

        unique case (cmd.op)
            ps2hlc_pkg::OP_LINE:
            begin
                unique case (mode_reg)
                    ps2hlc_pkg::MODE_WAIT_IDLE:
                    begin
                        if (cmd.clk_level && cmd.data_level)
                        begin
                            mode_next = ps2hlc_pkg::MODE_IDLE;
                        end
                    end
                    ps2hlc_pkg::MODE_IDLE:
                    begin
                        if (!cmd.clk_level)
                        begin
                            for (int i = 0; i < ps2hlc_pkg::RX_FRAME_BITS; i++)
                            begin
                                if (cmd.data_level &&
                                    receive_position_reg == ps2hlc_pkg::COUNT_BITS'(i))
                                begin
                                    receive_shift_next[i] = 1'b1;
                                end
                            end
                            receive_position_next = receive_position_reg + 1'b1;
                            bits_left_next = bits_left_reg - 1'b1;
                            if (bits_left_next == '0)
                            begin
                                result.frame = ps2hlc_pkg::frame_of(receive_shift_next);
                                result.frame_valid = 1'b1;
                                bits_left_next =
                                    ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::RX_FRAME_BITS);
                                receive_shift_next = '0;
                                receive_position_next = '0;
                            end
                        end
                    end
                    ps2hlc_pkg::MODE_WRITE:
                    begin
                        if (cmd.clk_level)
                        begin
                            data_held_next = ~transmit_shift_reg[0];
                            transmit_shift_next = {1'b1,
                                transmit_shift_reg[ps2hlc_pkg::TX_FRAME_BITS-1:1]};
                            if (bits_left_reg != '0)
                            begin
                                bits_left_next = bits_left_reg - 1'b1;
                            end
                        end
                        else if (bits_left_reg == '0)
                        begin
                            data_held_next = 1'b0;
                            transmit_shift_next = '1;
                            bits_left_next = ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::RX_FRAME_BITS);
                            receive_shift_next = '0;
                            receive_position_next = '0;
                            mode_next = ps2hlc_pkg::MODE_IDLE;
                            result.status = ps2hlc_pkg::STATUS_FINISHED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ps2hlc_pkg::OP_WRITE:
            begin
                if (mode_reg == ps2hlc_pkg::MODE_IDLE)
                begin
                    receive_shift_next = '0;
                    receive_position_next = '0;
                    bits_left_next = ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::TX_FRAME_BITS);
                    transmit_shift_next = cmd.tx_frame;
                    hold_count_next = '0;
                    clk_held_next = 1'b1;
                    mode_next = ps2hlc_pkg::MODE_HOLD_CLK;
                    result.status = ps2hlc_pkg::STATUS_ACCEPTED;
                end
                else
                begin
                    result.status = ps2hlc_pkg::STATUS_REJECTED;
                end
            end
            ps2hlc_pkg::OP_TICK:
            begin
                if (mode_reg == ps2hlc_pkg::MODE_HOLD_CLK ||
                    mode_reg == ps2hlc_pkg::MODE_HOLD_DATA)
                begin
                    hold_count_next = hold_done ? '0 : hold_inc;
                    if (hold_done && mode_reg == ps2hlc_pkg::MODE_HOLD_CLK)
                    begin
                        data_held_next = 1'b1;
                        mode_next = ps2hlc_pkg::MODE_HOLD_DATA;
                    end
                    else if (hold_done)
                    begin
                        clk_held_next = 1'b0;
                        mode_next = ps2hlc_pkg::MODE_WRITE;
                    end
                end
            end
            default:
            begin
                mode_next = ps2hlc_pkg::MODE_IDLE;
                bits_left_next = ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::RX_FRAME_BITS);
                receive_shift_next = '0;
                receive_position_next = '0;
                transmit_shift_next = '1;
                hold_count_next = '0;
                clk_held_next = 1'b0;
                data_held_next = 1'b0;
            end
        endcase

        result.clk_drive_low = clk_held_next;
        result.data_drive_low = data_held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inhibit_ticks_reg <= ps2hlc_pkg::INHIBIT_RESET;
        end
        else if (cfg_valid)
        begin
            inhibit_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ps2hlc_pkg::MODE_WAIT_IDLE;
            bits_left_reg <= ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::RX_FRAME_BITS);
            receive_shift_reg <= '0;
            receive_position_reg <= '0;
            transmit_shift_reg <= '1;
            hold_count_reg <= '0;
            clk_held_reg <= 1'b0;
            data_held_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            bits_left_reg <= bits_left_next;
            receive_shift_reg <= receive_shift_next;
            receive_position_reg <= receive_position_next;
            transmit_shift_reg <= transmit_shift_next;
            hold_count_reg <= hold_count_next;
            clk_held_reg <= clk_held_next;
            data_held_reg <= data_held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= result;
        end
    end

endmodule

>>> rtl/core/ps2_host_line_controller.sv
// An accepted transaction goes through the command queue and then the result register.
// Throughput: one transaction per cycle while rsp_stall is low, carried by the two-entry
// command queue and the single result register, refilled in the cycle it is taken.
// Reset (rst_n low, asynchronous) empties the queue and the result register,
// sets inhibit_ticks to 50000 and waits for both lines to be seen high.
module ps2_host_line_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ps2hlc_pkg::req_t                    req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ps2hlc_pkg::rsp_t                    rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2hlc_pkg::HOLD_BITS-1:0]    cfg_data
);

    logic              cmd_valid;
    logic              cmd_pop;
    ps2hlc_pkg::cmd_t  cmd;

    assign cfg_ready = 1'b1;

    ps2hlc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    ps2hlc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A received frame only ever arrives while both lines are released.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.frame_valid |->
            !rsp.clk_drive_low && !rsp.data_drive_low && rsp.status == ps2hlc_pkg::STATUS_NONE)
    else $error("frame delivered while driving the line or reporting a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.frame_valid |-> rsp.frame == '0)
    else $error("frame bits set without a completed frame");

    // An accepted write starts by holding the clock low; a finished one lets go of both.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ps2hlc_pkg::STATUS_ACCEPTED |->
            rsp.clk_drive_low && !rsp.data_drive_low)
    else $error("accepted write does not begin the clock hold");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ps2hlc_pkg::STATUS_FINISHED |->
            !rsp.clk_drive_low && !rsp.data_drive_low)
    else $error("finished write still drives a line");

    // The queue always pops while a command waits and the result slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !rsp_valid |-> cmd_pop)
    else $error("command queue stalled with a free result slot");

endmodule

>>> bench/tb_ps2_host_line_controller.sv
module tb_ps2_host_line_controller;

    typedef struct {
        ps2hlc_pkg::req_t item;
        bit               typed;
        ps2hlc_pkg::rsp_t want;
    } dir_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    ps2hlc_pkg::req_t                 req = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    ps2hlc_pkg::rsp_t                 rsp;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ps2hlc_pkg::HOLD_BITS-1:0] cfg_data = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int sent = 0;
    int checked = 0;
    int hold_plan [9] = '{1, 0, 3, 2, 7, 1, 4, 65535, 5};

    ps2hlc_pkg::rsp_t line_results_due[$];
    ps2hlc_pkg::rsp_t mon_want;
    dir_row_t         dir_tab [24];

    // Predicted state of the line controller.
    ps2hlc_pkg::mode_t                    ln_mode;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]    ln_bits_left;
    logic [ps2hlc_pkg::RX_FRAME_BITS-1:0] ln_rx_shift;
    logic [ps2hlc_pkg::COUNT_BITS-1:0]    ln_rx_pos;
    logic [ps2hlc_pkg::TX_FRAME_BITS-1:0] ln_tx_shift;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]     ln_hold;
    logic                                 ln_clk_held;
    logic                                 ln_data_held;
    logic [ps2hlc_pkg::HOLD_BITS-1:0]     ln_inhibit;

    ps2_host_line_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report(input string what, input ps2hlc_pkg::rsp_t got,
                          input ps2hlc_pkg::rsp_t want);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("mismatch at %0t: %s, got %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic rx_clear();
        ln_bits_left = ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::RX_FRAME_BITS);
        ln_rx_shift = '0;
        ln_rx_pos = '0;
    endtask

    task automatic host_line_reset();
        ln_inhibit = ps2hlc_pkg::INHIBIT_RESET;
        ln_mode = ps2hlc_pkg::MODE_WAIT_IDLE;
        rx_clear();
        ln_tx_shift = '1;
        ln_hold = '0;
        ln_clk_held = 1'b0;
        ln_data_held = 1'b0;
    endtask

    function automatic bit hold_elapsed();
        logic [ps2hlc_pkg::HOLD_BITS-1:0] lim;
        lim = (ln_inhibit == '0) ? ps2hlc_pkg::HOLD_BITS'(1) : ln_inhibit;
        ln_hold = ln_hold + ps2hlc_pkg::HOLD_BITS'(1);
        if (ln_hold >= lim)
        begin
            ln_hold = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic host_line_step(input ps2hlc_pkg::req_t it, output ps2hlc_pkg::rsp_t res);
        logic [ps2hlc_pkg::COUNT_BITS-1:0] pos;
        logic [ps2hlc_pkg::FRAME_BITS-1:0] frame;
        logic                              fv;
        ps2hlc_pkg::status_t               st;
        frame = '0;
        fv = 1'b0;
        st = ps2hlc_pkg::STATUS_NONE;
        case (ps2hlc_pkg::opcode_t'(it.opcode))
            ps2hlc_pkg::OP_LINE:
            begin
                if (ln_mode == ps2hlc_pkg::MODE_WAIT_IDLE)
                begin
                    if (it.clk_level && it.data_level)
                    begin
                        ln_mode = ps2hlc_pkg::MODE_IDLE;
                    end
                end
                else if (ln_mode == ps2hlc_pkg::MODE_IDLE)
                begin
                    if (!it.clk_level)
                    begin
                        pos = ln_rx_pos;
                        if (it.data_level && pos < ps2hlc_pkg::RX_FRAME_BITS)
                        begin
                            ln_rx_shift[pos] = 1'b1;
                        end
                        ln_rx_pos = pos + 1'b1;
                        ln_bits_left = ln_bits_left - 1'b1;
                        if (ln_bits_left == '0)
                        begin
                            frame = ln_rx_shift;
                            fv = 1'b1;
                            rx_clear();
                        end
                    end
                end
                else if (ln_mode == ps2hlc_pkg::MODE_WRITE)
                begin
                    if (it.clk_level)
                    begin
                        ln_data_held = ~ln_tx_shift[0];
                        ln_tx_shift = {1'b1, ln_tx_shift[ps2hlc_pkg::TX_FRAME_BITS-1:1]};
                        if (ln_bits_left != '0)
                        begin
                            ln_bits_left = ln_bits_left - 1'b1;
                        end
                    end
                    else if (ln_bits_left == '0)
                    begin
                        ln_data_held = 1'b0;
                        ln_tx_shift = '1;
                        rx_clear();
                        ln_mode = ps2hlc_pkg::MODE_IDLE;
                        st = ps2hlc_pkg::STATUS_FINISHED;
                    end
                end
            end
            ps2hlc_pkg::OP_WRITE:
            begin
                if (ln_mode == ps2hlc_pkg::MODE_IDLE)
                begin
                    rx_clear();
                    ln_bits_left = ps2hlc_pkg::COUNT_BITS'(ps2hlc_pkg::TX_FRAME_BITS);
                    ln_tx_shift = '1;
                    ln_tx_shift[7:0] = it.write_byte;
                    ln_tx_shift[8] = ~^it.write_byte;
                    ln_hold = '0;
                    ln_clk_held = 1'b1;
                    ln_mode = ps2hlc_pkg::MODE_HOLD_CLK;
                    st = ps2hlc_pkg::STATUS_ACCEPTED;
                end
                else
                begin
                    st = ps2hlc_pkg::STATUS_REJECTED;
                end
            end
            ps2hlc_pkg::OP_TICK:
            begin
                if (ln_mode == ps2hlc_pkg::MODE_HOLD_CLK)
                begin
                    if (hold_elapsed())
                    begin
                        ln_data_held = 1'b1;
                        ln_mode = ps2hlc_pkg::MODE_HOLD_DATA;
                    end
                end
                else if (ln_mode == ps2hlc_pkg::MODE_HOLD_DATA)
                begin
                    if (hold_elapsed())
                    begin
                        ln_clk_held = 1'b0;
                        ln_mode = ps2hlc_pkg::MODE_WRITE;
                    end
                end
            end
            default:
            begin
                ln_mode = ps2hlc_pkg::MODE_IDLE;
                rx_clear();
                ln_tx_shift = '1;
                ln_hold = '0;
                ln_clk_held = 1'b0;
                ln_data_held = 1'b0;
            end
        endcase
        res.frame = frame;
        res.frame_valid = fv;
        res.clk_drive_low = ln_clk_held;
        res.data_drive_low = ln_data_held;
        res.status = st;
    endtask

    // Mostly well-formed line traffic for the predicted mode, with some noise.
    function automatic ps2hlc_pkg::req_t next_line_item();
        ps2hlc_pkg::req_t it;
        int               r;
        it.opcode = ps2hlc_pkg::OP_LINE;
        it.clk_level = 1'($urandom);
        it.data_level = 1'($urandom);
        it.write_byte = 8'($urandom);
        r = $urandom_range(0, 99);
        case (ln_mode)
            ps2hlc_pkg::MODE_IDLE:
            begin
                if (ln_rx_pos == '0)
                begin
                    if (r < 22)
                        it.opcode = ps2hlc_pkg::OP_WRITE;
                    else if (r < 30)
                        it.clk_level = 1'b1;
                    else if (r < 34)
                        it.opcode = ps2hlc_pkg::OP_TICK;
                    else if (r < 36)
                        it.opcode = ps2hlc_pkg::OP_FORCE_IDLE;
                    else
                        it.clk_level = 1'b0;
                end
                else
                begin
                    if (r < 2)
                        it.opcode = ps2hlc_pkg::OP_WRITE;
                    else if (r < 4)
                        it.opcode = ps2hlc_pkg::OP_FORCE_IDLE;
                    else if (r < 20)
                        it.clk_level = 1'b1;
                    else if (r < 24)
                        it.opcode = ps2hlc_pkg::OP_TICK;
                    else
                        it.clk_level = 1'b0;
                end
            end
            ps2hlc_pkg::MODE_HOLD_CLK, ps2hlc_pkg::MODE_HOLD_DATA:
            begin
                if (r < 80)
                    it.opcode = ps2hlc_pkg::OP_TICK;
                else if (r < 95 && r >= 88)
                    it.opcode = ps2hlc_pkg::OP_WRITE;
                else if (r >= 95)
                    it.opcode = ps2hlc_pkg::OP_FORCE_IDLE;
            end
            ps2hlc_pkg::MODE_WRITE:
            begin
                if (ln_bits_left != '0)
                begin
                    if (r < 62)
                        it.clk_level = 1'b1;
                    else if (r < 88)
                        it.clk_level = 1'b0;
                    else if (r < 94)
                        it.opcode = ps2hlc_pkg::OP_TICK;
                    else if (r < 99)
                        it.opcode = ps2hlc_pkg::OP_WRITE;
                    else
                        it.opcode = ps2hlc_pkg::OP_FORCE_IDLE;
                end
                else
                begin
                    if (r < 55)
                        it.clk_level = 1'b0;
                    else if (r < 85)
                        it.clk_level = 1'b1;
                    else if (r < 95)
                        it.opcode = ps2hlc_pkg::OP_TICK;
                    else
                        it.opcode = ps2hlc_pkg::OP_WRITE;
                end
            end
            default:
            begin
                if (r < 40)
                begin
                    it.clk_level = 1'b1;
                    it.data_level = 1'b1;
                end
            end
        endcase
        return it;
    endfunction

    function automatic dir_row_t row(input ps2hlc_pkg::opcode_t op, input logic c,
                                     input logic d, input logic [7:0] b, input bit typed,
                                     input logic [ps2hlc_pkg::FRAME_BITS-1:0] f,
                                     input logic fv, input logic cl, input logic dl,
                                     input ps2hlc_pkg::status_t st);
        dir_row_t x;
        x.item.opcode = op;
        x.item.clk_level = c;
        x.item.data_level = d;
        x.item.write_byte = b;
        x.typed = typed;
        x.want.frame = f;
        x.want.frame_valid = fv;
        x.want.clk_drive_low = cl;
        x.want.data_drive_low = dl;
        x.want.status = st;
        return x;
    endfunction

    task automatic drive_item(input ps2hlc_pkg::req_t it, input bit typed,
                              input ps2hlc_pkg::rsp_t want);
        ps2hlc_pkg::rsp_t predicted;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        host_line_step(it, predicted);
        line_results_due.push_back(typed ? want : predicted);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_inhibit(input logic [ps2hlc_pkg::HOLD_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        ln_inhibit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (line_results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (line_results_due.size() == 0)
            begin
                report("result with no transaction awaiting it", rsp, '0);
            end
            else
            begin
                mon_want = line_results_due.pop_front();
                checked++;
                if (rsp.frame !== mon_want.frame)
                    report("frame", rsp, mon_want);
                if (rsp.frame_valid !== mon_want.frame_valid)
                    report("frame_valid", rsp, mon_want);
                if (rsp.clk_drive_low !== mon_want.clk_drive_low)
                    report("clk_drive_low", rsp, mon_want);
                if (rsp.data_drive_low !== mon_want.data_drive_low)
                    report("data_drive_low", rsp, mon_want);
                if (rsp.status !== mon_want.status)
                    report("status", rsp, mon_want);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int i;
        int p;
        int n;
        int budget;
        host_line_reset();
        dir_tab[0] = row(ps2hlc_pkg::OP_WRITE, 1'b0, 1'b0, 8'hA5, 1, '0, 1'b0, 1'b0, 1'b0,
                         ps2hlc_pkg::STATUS_REJECTED);
        dir_tab[1] = row(ps2hlc_pkg::OP_TICK, 1'b0, 1'b0, 8'h00, 1, '0, 1'b0, 1'b0, 1'b0,
                         ps2hlc_pkg::STATUS_NONE);
        dir_tab[2] = row(ps2hlc_pkg::OP_LINE, 1'b0, 1'b1, 8'h00, 1, '0, 1'b0, 1'b0, 1'b0,
                         ps2hlc_pkg::STATUS_NONE);
        dir_tab[3] = row(ps2hlc_pkg::OP_LINE, 1'b1, 1'b0, 8'h00, 1, '0, 1'b0, 1'b0, 1'b0,
                         ps2hlc_pkg::STATUS_NONE);
        dir_tab[4] = row(ps2hlc_pkg::OP_LINE, 1'b1, 1'b1, 8'h00, 1, '0, 1'b0, 1'b0, 1'b0,
                         ps2hlc_pkg::STATUS_NONE);
        for (i = 0; i < 11; i++)
        begin
            dir_tab[5 + i] = row(ps2hlc_pkg::OP_LINE, 1'b0, 1'b1, 8'h00, 1,
                                 (i == 10) ? 11'h7ff : 11'h000, (i == 10), 1'b0, 1'b0,
                                 ps2hlc_pkg::STATUS_NONE);
        end
        dir_tab[16] = row(ps2hlc_pkg::OP_WRITE, 1'b0, 1'b0, 8'h00, 1, '0, 1'b0, 1'b1, 1'b0,
                          ps2hlc_pkg::STATUS_ACCEPTED);
        dir_tab[17] = row(ps2hlc_pkg::OP_WRITE, 1'b0, 1'b0, 8'hFF, 1, '0, 1'b0, 1'b1, 1'b0,
                          ps2hlc_pkg::STATUS_REJECTED);
        dir_tab[18] = row(ps2hlc_pkg::OP_TICK, 1'b0, 1'b0, 8'h00, 0, '0, 1'b0, 1'b0, 1'b0,
                          ps2hlc_pkg::STATUS_NONE);
        dir_tab[19] = row(ps2hlc_pkg::OP_LINE, 1'b0, 1'b0, 8'h00, 0, '0, 1'b0, 1'b0, 1'b0,
                          ps2hlc_pkg::STATUS_NONE);
        dir_tab[20] = row(ps2hlc_pkg::OP_FORCE_IDLE, 1'b0, 1'b0, 8'h00, 1, '0, 1'b0, 1'b0,
                          1'b0, ps2hlc_pkg::STATUS_NONE);
        dir_tab[21] = row(ps2hlc_pkg::OP_FORCE_IDLE, 1'b1, 1'b1, 8'hFF, 0, '0, 1'b0, 1'b0,
                          1'b0, ps2hlc_pkg::STATUS_NONE);
        dir_tab[22] = row(ps2hlc_pkg::OP_WRITE, 1'b1, 1'b1, 8'hFF, 1, '0, 1'b0, 1'b1, 1'b0,
                          ps2hlc_pkg::STATUS_ACCEPTED);
        dir_tab[23] = row(ps2hlc_pkg::OP_FORCE_IDLE, 1'b0, 1'b0, 8'h00, 1, '0, 1'b0, 1'b0,
                          1'b0, ps2hlc_pkg::STATUS_NONE);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct = 32;
        stall_pct = 48;
        for (i = 0; i < 24; i++)
        begin
            drive_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end
        settle();

        for (p = 0; p < 9; p++)
        begin
            gap_pct = (p < 3) ? 32 : (p < 6) ? 48 : 0;
            stall_pct = (p < 3) ? 48 : (p < 6) ? 32 : 0;
            write_inhibit(ps2hlc_pkg::HOLD_BITS'(hold_plan[p]));
            budget = (hold_plan[p] > 16) ? 40 : 240;
            n = 0;
            while (n < budget || ln_mode != ps2hlc_pkg::MODE_IDLE)
            begin
                drive_item(next_line_item(), 0, '0);
                n++;
            end
            settle();
        end

        $display("summary: %0d transactions sent and %0d results checked", sent, checked);
        $display("summary: hold lengths 0 to 65535 ticks, frames, writes and aborts");
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
